/* rtl/ffba_pkg.sv */
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int MAX_PAGES    = 16;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int GRAN_BYTES   = 16;

  localparam int SZ_W   = 17;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PG_W   = 5;
  localparam int OFF_W  = 16;

  typedef struct packed {
    logic [SZ_W-1:0] size;
    logic            free;
  } entry_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_LOAD
  } stk_op_e;

  typedef struct packed {
    stk_op_e op;
    entry_t  din;
  } stk_cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOROOM  = 3'd2,
    ST_BADOFF  = 3'd3,
    ST_DOUBLE  = 3'd4
  } status_e;

endpackage

/* rtl/ffba_cell.sv */
module ffba_cell import ffba_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  stk_op_e op_i,
  input  entry_t  rst_val_i,
  input  entry_t  from_prev_i,
  input  entry_t  from_next_i,
  output entry_t  q_o
);

  entry_t val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= rst_val_i;
    end else begin
      case (op_i)
        STK_PUSH: val_q <= from_prev_i;
        STK_POP:  val_q <= from_next_i;
        STK_LOAD: val_q <= from_prev_i;
        default:  val_q <= val_q;
      endcase
    end
  end

  assign q_o = val_q;

endmodule

/* rtl/ffba_stack.sv */
module ffba_stack import ffba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  stk_cmd_t cmd_i,
  input  entry_t   rst_top_i,
  output entry_t   top_o
);

  entry_t cell_q [MAX_BLOCKS];

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    entry_t  prev_w, next_w, rst_w;
    stk_op_e op_w;

    // only the top cell takes a load; the rest keep their value
    assign op_w   = (i != 0 && cmd_i.op == STK_LOAD) ? STK_HOLD : cmd_i.op;
    assign prev_w = (i == 0) ? cmd_i.din : cell_q[(i == 0) ? 0 : i - 1];
    assign next_w = (i == MAX_BLOCKS - 1) ? entry_t'('0)
                                          : cell_q[(i == MAX_BLOCKS - 1) ? i : i + 1];
    assign rst_w  = (i == 0) ? rst_top_i : entry_t'('0);

    ffba_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op_w),
      .rst_val_i   (rst_w),
      .from_prev_i (prev_w),
      .from_next_i (next_w),
      .q_o         (cell_q[i])
    );
  end

  assign top_o = cell_q[0];

endmodule

/* rtl/first_fit_block_allocator_unit.sv */
// Channel   Direction  Handshake           Payload
// request   in         start_i / busy_o    action_i, request_bytes_i, data_offset_in_i
// result    out        done_o (1 cycle)    status_o, data_offset_out_o, bytes_in_use_o,
//                                          bytes_free_o
// config    in         page_limit_we_i     page_limit_i
//
// The block table lives in two stacks of cells with a cursor between them; each
// scan or walk cycle moves the cursor one block. A request scans out along the
// table, then walks back; each page added means an append, a further scan over
// it and a walk back. A zero-size request or a free of offset 0 answers at once.
// Reset leaves one free page, limit 16. The receiver cannot stall: done_o is a
// single-cycle strobe, and a new start may be taken in the same cycle.
module first_fit_block_allocator_unit import ffba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               action_i,
  input  logic [OFF_W-1:0]   request_bytes_i,
  input  logic [OFF_W-1:0]   data_offset_in_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [OFF_W-1:0]   data_offset_out_o,
  output logic [SZ_W-1:0]    bytes_in_use_o,
  output logic [SZ_W-1:0]    bytes_free_o,
  input  logic               page_limit_we_i,
  input  logic [PG_W-1:0]    page_limit_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_FWD,
    S_REWIND
  } state_e;

  localparam entry_t PAGE_ENTRY = '{size: SZ_W'(PAGE_BYTES), free: 1'b1};

  state_e            state_q, state_d;
  logic              act_q, act_d;
  logic [SZ_W-1:0]   needed_q, needed_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [SZ_W-1:0]   start_q, start_d;
  logic [CNT_W-1:0]  lcnt_q, lcnt_d, rcnt_q, rcnt_d, count_w;
  logic [PG_W-1:0]   pages_q, pages_d, limit_q, lim_w;
  logic [PG_W-1:0]   added_q, added_d;
  logic              grown_q, grown_d, merge_q, merge_d;
  logic [SZ_W-1:0]   used_q, used_d, free_q, free_d;
  status_e           status_q, status_d;
  logic [OFF_W-1:0]  resoff_q, resoff_d;
  logic              done_q, done_d;

  stk_cmd_t lcmd, rcmd;
  entry_t   ltop, rtop;

  ffba_stack u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (lcmd),
    .rst_top_i (entry_t'('0)),
    .top_o     (ltop)
  );

  ffba_stack u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (rcmd),
    .rst_top_i (PAGE_ENTRY),
    .top_o     (rtop)
  );

  assign count_w = lcnt_q + rcnt_q;
  assign lim_w   = (limit_q > PG_W'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : limit_q;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    needed_d = needed_q;
    off_d    = off_q;
    start_d  = start_q;
    lcnt_d   = lcnt_q;
    rcnt_d   = rcnt_q;
    pages_d  = pages_q;
    added_d  = added_q;
    grown_d  = grown_q;
    merge_d  = merge_q;
    used_d   = used_q;
    free_d   = free_q;
    status_d = status_q;
    resoff_d = resoff_q;
    done_d   = 1'b0;
    lcmd     = '{op: STK_HOLD, din: '0};
    rcmd     = '{op: STK_HOLD, din: '0};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d    = action_i;
          off_d    = data_offset_in_i;
          start_d  = '0;
          grown_d  = 1'b0;
          merge_d  = 1'b0;
          added_d  = '0;
          resoff_d = '0;
          status_d = ST_OK;
          needed_d = ((SZ_W'(request_bytes_i) + SZ_W'(GRAN_BYTES - 1))
                      & ~SZ_W'(GRAN_BYTES - 1)) + SZ_W'(HEADER_BYTES);
          if (!action_i && request_bytes_i == '0) begin
            status_d = ST_ZERO;
            done_d   = 1'b1;
          end else if (action_i && data_offset_in_i == '0) begin
            done_d   = 1'b1;
          end else begin
            state_d  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (rcnt_q == '0) begin
          if (act_q) begin
            status_d = ST_BADOFF;
            state_d  = S_REWIND;
          end else if (grown_q) begin
            status_d = ST_NOROOM;
            state_d  = S_REWIND;
          end else begin
            state_d  = S_GROW;
          end
        end else if (!act_q && rtop.free && rtop.size >= needed_q) begin
          resoff_d = OFF_W'(start_q + SZ_W'(HEADER_BYTES));
          lcnt_d   = lcnt_q + 1'b1;
          state_d  = S_REWIND;
          if ({1'b0, rtop.size} >= {1'b0, needed_q} + (SZ_W+1)'(HEADER_BYTES + GRAN_BYTES)
              && count_w < CNT_W'(MAX_BLOCKS)) begin
            // split: the allocated part goes left, the remainder stays on top
            lcmd   = '{op: STK_PUSH, din: '{size: needed_q, free: 1'b0}};
            rcmd   = '{op: STK_LOAD, din: '{size: rtop.size - needed_q, free: 1'b1}};
            used_d = used_q + needed_q;
            free_d = free_q - needed_q;
          end else begin
            lcmd   = '{op: STK_PUSH, din: '{size: rtop.size, free: 1'b0}};
            rcmd   = '{op: STK_POP, din: '0};
            rcnt_d = rcnt_q - 1'b1;
            used_d = used_q + rtop.size;
            free_d = free_q - rtop.size;
          end
        end else if (act_q && ({1'b0, start_q} + (SZ_W+1)'(HEADER_BYTES))
                              == (SZ_W+1)'(off_q)) begin
          if (rtop.free) begin
            status_d = ST_DOUBLE;
            state_d  = S_REWIND;
          end else begin
            rcmd     = '{op: STK_LOAD, din: '{size: rtop.size, free: 1'b1}};
            free_d   = free_q + rtop.size;
            used_d   = used_q - rtop.size;
            state_d  = S_FWD;
          end
        end else begin
          lcmd    = '{op: STK_PUSH, din: rtop};
          rcmd    = '{op: STK_POP, din: '0};
          lcnt_d  = lcnt_q + 1'b1;
          rcnt_d  = rcnt_q - 1'b1;
          start_d = start_q + rtop.size;
        end
      end

      S_GROW: begin
        if ((SZ_W+1)'(added_q) * (SZ_W+1)'(PAGE_BYTES) >= (SZ_W+1)'(needed_q)) begin
          grown_d = 1'b1;
          state_d = S_SCAN;
        end else if (pages_q >= lim_w || count_w >= CNT_W'(MAX_BLOCKS)) begin
          status_d = ST_NOROOM;
          state_d  = S_REWIND;
        end else begin
          // cursor sits at the table end, so a push on the right appends
          rcmd    = '{op: STK_PUSH, din: PAGE_ENTRY};
          rcnt_d  = rcnt_q + 1'b1;
          pages_d = pages_q + 1'b1;
          added_d = added_q + 1'b1;
          free_d  = free_q + SZ_W'(PAGE_BYTES);
        end
      end

      S_FWD: begin
        if (rcnt_q == '0) begin
          merge_d = 1'b1;
          state_d = S_REWIND;
        end else if (lcnt_q != '0 && ltop.free && rtop.free) begin
          lcmd   = '{op: STK_LOAD, din: '{size: ltop.size + rtop.size, free: 1'b1}};
          rcmd   = '{op: STK_POP, din: '0};
          rcnt_d = rcnt_q - 1'b1;
        end else begin
          lcmd   = '{op: STK_PUSH, din: rtop};
          rcmd   = '{op: STK_POP, din: '0};
          lcnt_d = lcnt_q + 1'b1;
          rcnt_d = rcnt_q - 1'b1;
        end
      end

      S_REWIND: begin
        if (lcnt_q == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (merge_q && rcnt_q != '0 && ltop.free && rtop.free) begin
          rcmd   = '{op: STK_LOAD, din: '{size: ltop.size + rtop.size, free: 1'b1}};
          lcmd   = '{op: STK_POP, din: '0};
          lcnt_d = lcnt_q - 1'b1;
        end else begin
          rcmd   = '{op: STK_PUSH, din: ltop};
          lcmd   = '{op: STK_POP, din: '0};
          lcnt_d = lcnt_q - 1'b1;
          rcnt_d = rcnt_q + 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      act_q    <= 1'b0;
      needed_q <= '0;
      off_q    <= '0;
      start_q  <= '0;
      lcnt_q   <= '0;
      rcnt_q   <= CNT_W'(1);
      pages_q  <= PG_W'(1);
      limit_q  <= PG_W'(MAX_PAGES);
      added_q  <= '0;
      grown_q  <= 1'b0;
      merge_q  <= 1'b0;
      used_q   <= '0;
      free_q   <= SZ_W'(PAGE_BYTES);
      status_q <= ST_OK;
      resoff_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      needed_q <= needed_d;
      off_q    <= off_d;
      start_q  <= start_d;
      lcnt_q   <= lcnt_d;
      rcnt_q   <= rcnt_d;
      pages_q  <= pages_d;
      added_q  <= added_d;
      grown_q  <= grown_d;
      merge_q  <= merge_d;
      used_q   <= used_d;
      free_q   <= free_d;
      status_q <= status_d;
      resoff_q <= resoff_d;
      done_q   <= done_d;
      if (page_limit_we_i) begin
        limit_q <= page_limit_i;
      end
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign data_offset_out_o = resoff_q;
  assign bytes_in_use_o    = used_q;
  assign bytes_free_o      = free_q;

  a_idle_cursor_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> lcnt_q == '0)
    else $error("cursor not at table start while idle");

  a_bytes_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((SZ_W+1)'(used_q) + (SZ_W+1)'(free_q))
      == (SZ_W+1)'(pages_q) * (SZ_W+1)'(PAGE_BYTES))
    else $error("used plus free bytes differ from arena size");

  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W+1)'(lcnt_q) + (CNT_W+1)'(rcnt_q) <= (CNT_W+1)'(MAX_BLOCKS))
    else $error("block table overflow");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REWIND && lcnt_q == '0) |=> done_o && !busy_o)
    else $error("walk back finished without a result");

endmodule
